/* hdl/commodity_channel_index_assert.svh */
// ----------------------------------------------------------------------------
// Commodity channel index assertion macros
// Concurrent checks on aclk, disabled while aresetn is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef COMMODITY_CHANNEL_INDEX_ASSERT_SVH
`define COMMODITY_CHANNEL_INDEX_ASSERT_SVH
`ifndef SYNTHESIS
`define CCI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define CCI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);
`else
`define CCI_ASSERT(lbl, prop, msg)
`define CCI_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

/* hdl/cci_pkg.sv */
// ----------------------------------------------------------------------------
// cci_pkg
// Widths, constants and controller/datapath interface types for the CCI block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cci_pkg;

    localparam int PRICE_BITS = 32;
    localparam int WINDOW_MAX = 64;
    localparam int RING_AW    = 6;          // log2(WINDOW_MAX)
    localparam int N_W        = 7;          // period / bar count
    localparam int X_W        = 35;         // sum of six prices
    localparam int TOT_W      = 41;         // window total, n*x
    localparam int DEV_W      = 47;         // deviation sum
    localparam int MAG_W      = 47;         // n*|n*x - S|
    localparam int SCL_W      = 52;         // mag * 25
    localparam int DIV_W      = 49;         // 3 * deviation sum
    localparam int NUM_W      = 63;         // mag * 51200
    localparam int OUT_W      = 24;
    localparam int IN_W       = 6 * PRICE_BITS;
    localparam int CFG_W      = 8;
    localparam int DIV_CNT_W  = 6;

    localparam logic [N_W-1:0]       PERIOD_RESET = N_W'(20);
    localparam logic [N_W-1:0]       PERIOD_MIN   = N_W'(2);
    localparam logic [N_W-1:0]       PERIOD_MAX   = N_W'(WINDOW_MAX);
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS    = DIV_CNT_W'(NUM_W);
    localparam logic [NUM_W-1:0]     POS_LIMIT    = NUM_W'(8388607);
    localparam logic [NUM_W-1:0]     NEG_LIMIT    = NUM_W'(8388608);
    localparam logic [OUT_W-1:0]     OUT_POS_SAT  = 24'h7FFFFF;
    localparam logic [OUT_W-1:0]     OUT_NEG_SAT  = 24'h800000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_UPDATE,
        ST_SCAN,
        ST_MAG,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic sum;
        logic update;
        logic scan;
        logic mag;
        logic scale;
        logic div;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic full_next;
        logic scan_done;
        logic flat;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

/* hdl/commodity_channel_index.sv */
// ----------------------------------------------------------------------------
// commodity_channel_index
// Commodity channel index of a price bar over a sliding window, signed Q8.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : period write (cfg_tdata[6:0]); restarts the window. Write only
//            while no bar is in flight. Values outside 2..64 clamp.
//   s_*    : one bar per transaction, six 32-bit prices in s_tdata.
//   m_*    : one result per bar; cci_q8 in m_tdata, flags in m_tuser.
// Sequence: during warm-up a bar passes through sum, window update and done.
//   With a full window of n bars the sequencer then sweeps the price ring
//   through its single read port, then runs the bit-serial divide (63 quotient
//   bits and a done check). A flat window skips the divide. One bar is
//   processed at a time; s_tready is high only while the sequencer is idle, so
//   a new bar is not taken until the previous result is loaded into the output
//   register.
// Reset: period returns to 20 and the window empties; ring contents are not
//   cleared, warm-up only reads entries written since the restart.
// Stall: the result sits in an output register; a new bar is accepted while it
//   waits, and the next result holds in the final step until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module commodity_channel_index (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_tvalid,
    output logic                      cfg_tready,
    input  logic [cci_pkg::CFG_W-1:0] cfg_tdata,  // [6:0] period, [7] unused
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [31:0] bid_high, [63:32] bid_low, [95:64] bid_close,
    // [127:96] ask_high, [159:128] ask_low, [191:160] ask_close
    input  logic [cci_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [cci_pkg::OUT_W-1:0] m_tdata,    // [23:0] cci_q8
    output logic [1:0]                m_tuser     // [0] window_full, [1] window_flat
);
    import cci_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_tready = 1'b1;

    cci_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cci_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_tvalid (cfg_tvalid),
        .cfg_tdata  (cfg_tdata),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

/* hdl/cci_ctrl.sv */
// ----------------------------------------------------------------------------
// cci_ctrl
// Sequencer: steps one bar through sum, window update, deviation scan and divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cci_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  cci_pkg::status_t status,
    output cci_pkg::cmd_t    cmd
);
    import cci_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_SUM;
            ST_SUM:    state_next = ST_UPDATE;
            ST_UPDATE: state_next = status.full_next ? ST_SCAN : ST_DONE;
            ST_SCAN: begin
                if (status.scan_done) state_next = status.flat ? ST_DONE : ST_MAG;
            end
            ST_MAG:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_DIV;
            ST_DIV:    if (status.div_done) state_next = ST_DONE;
            ST_DONE:   if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_SUM:    cmd.sum    = 1'b1;
            ST_UPDATE: cmd.update = 1'b1;
            ST_SCAN:   cmd.scan   = 1'b1;
            ST_MAG:    cmd.mag    = 1'b1;
            ST_SCALE:  cmd.scale  = 1'b1;
            ST_DIV:    cmd.div    = 1'b1;
            ST_DONE:   cmd.load   = status.out_free;
            default:   cmd        = '0;
        endcase
    end

endmodule

/* hdl/cci_datapath.sv */
// ----------------------------------------------------------------------------
// cci_datapath
// Price ring, running total, deviation accumulator, serial divider, output reg.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "commodity_channel_index_assert.svh"

module cci_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_tvalid,
    input  logic [cci_pkg::CFG_W-1:0]     cfg_tdata,
    input  logic [cci_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cci_pkg::OUT_W-1:0]     m_tdata,
    output logic [1:0]                    m_tuser,
    input  cci_pkg::cmd_t                 cmd,
    output cci_pkg::status_t              status
);
    import cci_pkg::*;

    // configuration and window bookkeeping
    logic [N_W-1:0]      period_reg;
    logic [N_W-1:0]      n;
    logic [RING_AW-1:0]  write_slot_reg;
    logic [N_W-1:0]      bars_seen_reg;
    logic [TOT_W-1:0]    total_reg;

    logic [RING_AW-1:0]  slot_eff;
    logic [N_W-1:0]      slot_inc;
    logic [N_W-1:0]      bars_next;
    logic                was_full;

    // item data
    logic [IN_W-1:0]     in_reg;
    logic [X_W-1:0]      x_reg;
    logic [TOT_W-1:0]    nx_reg;
    logic [2*N_W+X_W-N_W-1:0] nx_full;

    // ring memory
    logic [X_W-1:0]      ring_mem [WINDOW_MAX];
    logic [X_W-1:0]      rd_data_reg;
    logic [RING_AW-1:0]  rd_addr;
    logic                rd_en;

    // deviation scan
    logic [N_W-1:0]      k_reg;
    logic                issue;
    logic                v1_reg, v2_reg, v3_reg;
    logic [TOT_W:0]      prod_full;
    logic [TOT_W-1:0]    prod_reg;
    logic [TOT_W-1:0]    absdiff_reg;
    logic [DEV_W-1:0]    dev_reg;

    // ratio
    logic                neg_reg;
    logic [TOT_W-1:0]    diff_reg;
    logic [MAG_W:0]      mag_full;
    logic [MAG_W-1:0]    mag_reg;
    logic [SCL_W-1:0]    scaled;
    logic [DIV_W-1:0]    divisor_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_W:0]      trial;
    logic                full_reg;

    // output
    logic                m_tvalid_reg;
    logic [OUT_W-1:0]    m_tdata_reg;
    logic [1:0]          m_tuser_reg;
    logic [OUT_W-1:0]    cci_value;
    logic                flat;

    assign n = (period_reg < PERIOD_MIN) ? PERIOD_MIN :
               (period_reg > PERIOD_MAX) ? PERIOD_MAX : period_reg;

    assign slot_eff  = ({1'b0, write_slot_reg} >= n) ? '0 : write_slot_reg;
    assign slot_inc  = {1'b0, slot_eff} + N_W'(1);
    assign was_full  = bars_seen_reg >= n;
    assign bars_next = was_full ? n : bars_seen_reg + N_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg     <= PERIOD_RESET;
            write_slot_reg <= '0;
            bars_seen_reg  <= '0;
            total_reg      <= '0;
        end else if (cfg_tvalid) begin
            period_reg     <= cfg_tdata[N_W-1:0];
            write_slot_reg <= '0;
            bars_seen_reg  <= '0;
            total_reg      <= '0;
        end else if (cmd.update) begin
            // rd_data_reg holds the entry being overwritten
            total_reg      <= total_reg - (was_full ? TOT_W'(rd_data_reg) : '0)
                              + TOT_W'(x_reg);
            write_slot_reg <= (slot_inc >= n) ? '0 : slot_inc[RING_AW-1:0];
            bars_seen_reg  <= bars_next;
        end
    end

    assign nx_full = n * x_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_tdata;
        end
        if (cmd.sum) begin
            x_reg <= X_W'(in_reg[0*PRICE_BITS +: PRICE_BITS])
                   + X_W'(in_reg[1*PRICE_BITS +: PRICE_BITS])
                   + X_W'(in_reg[2*PRICE_BITS +: PRICE_BITS])
                   + X_W'(in_reg[3*PRICE_BITS +: PRICE_BITS])
                   + X_W'(in_reg[4*PRICE_BITS +: PRICE_BITS])
                   + X_W'(in_reg[5*PRICE_BITS +: PRICE_BITS]);
        end
        if (cmd.update) begin
            nx_reg <= nx_full[TOT_W-1:0];
        end
    end

    // ring: old entry read in the sum cycle, new one written at update
    assign issue   = cmd.scan && (k_reg < n);
    assign rd_addr = cmd.sum ? slot_eff : k_reg[RING_AW-1:0];
    assign rd_en   = cmd.sum || issue;

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            ring_mem[slot_eff] <= x_reg;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    // deviation scan pipeline: read, n*x_k, |n*x_k - S|, accumulate
    assign prod_full = n * rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg  <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (cmd.update) begin
            k_reg  <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (issue) begin
                k_reg <= k_reg + N_W'(1);
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[TOT_W-1:0];
        absdiff_reg <= (prod_reg >= total_reg) ? prod_reg - total_reg
                                               : total_reg - prod_reg;
        if (cmd.update) begin
            dev_reg  <= '0;
            full_reg <= (bars_next == n);
        end else if (v3_reg) begin
            dev_reg <= dev_reg + DEV_W'(absdiff_reg);
        end
        if (cmd.scan) begin
            neg_reg  <= nx_reg < total_reg;
            diff_reg <= (nx_reg < total_reg) ? total_reg - nx_reg : nx_reg - total_reg;
        end
    end

    // ratio: mag * 51200 / (3 * D), restoring divide one bit a cycle
    assign mag_full = n * diff_reg;
    assign scaled   = (SCL_W'(mag_reg) << 4) + (SCL_W'(mag_reg) << 3) + SCL_W'(mag_reg);
    assign trial    = {rem_reg, num_reg[NUM_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.mag) begin
            mag_reg     <= mag_full[MAG_W-1:0];
            divisor_reg <= {1'b0, dev_reg, 1'b0} + {2'b00, dev_reg};
        end
        if (cmd.scale) begin
            num_reg     <= {scaled, 11'b0};
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div && (div_cnt_reg != DIV_STEPS)) begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            if (trial >= {1'b0, divisor_reg}) begin
                rem_reg <= DIV_W'(trial - {1'b0, divisor_reg});
                num_reg <= {num_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DIV_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // num_reg holds the quotient once the divide completes
    always_comb begin
        if (neg_reg) begin
            cci_value = (num_reg > NEG_LIMIT) ? OUT_NEG_SAT : OUT_W'(0) - num_reg[OUT_W-1:0];
        end else begin
            cci_value = (num_reg > POS_LIMIT) ? OUT_POS_SAT : num_reg[OUT_W-1:0];
        end
    end

    assign flat = full_reg && (dev_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_tdata_reg <= (full_reg && !flat) ? cci_value : '0;
            m_tuser_reg <= {flat, full_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign status.full_next = (bars_next == n);
    assign status.scan_done = (k_reg == n) && !v1_reg && !v2_reg && !v3_reg;
    assign status.flat      = (dev_reg == '0);
    assign status.div_done  = (div_cnt_reg == DIV_STEPS);
    assign status.out_free  = !m_tvalid_reg || m_tready;

    `CCI_ASSERT(a_slot_in_window, {1'b0, write_slot_reg} < n, "write slot beyond window")
    `CCI_ASSERT(a_bars_bounded, bars_seen_reg <= n, "bar count exceeds period")
    `CCI_ASSERT_IMPL(a_div_nonzero, cmd.div, divisor_reg != '0, "divide by zero deviation")
    `CCI_ASSERT_IMPL(a_load_free, cmd.load, !m_tvalid_reg || m_tready, "result overwritten")

endmodule
